/* rtl/core/wlsf_pkg.sv */
// Shared types and codes for the worker lifecycle / shutdown FSM.
// No dependencies; used by every file under rtl/core.
package wlsf_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned OwnerW = 16;
  localparam int unsigned ReplyW = 2;
  localparam int unsigned StateW = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned SigW   = 2;
  localparam int unsigned TickW  = 16;

  localparam logic [TickW-1:0] TimeoutReset = TickW'(10);
  localparam logic [TickW-1:0] TickMax      = {TickW{1'b1}};

  // lifecycle states
  localparam logic [StateW-1:0] StStart    = 3'd0;
  localparam logic [StateW-1:0] StInit     = 3'd1;
  localparam logic [StateW-1:0] StIdle     = 3'd2;
  localparam logic [StateW-1:0] StOpenIdle = 3'd3;
  localparam logic [StateW-1:0] StBusy     = 3'd4;
  localparam logic [StateW-1:0] StTerm     = 3'd5;
  localparam logic [StateW-1:0] StKill     = 3'd6;
  localparam logic [StateW-1:0] StExit     = 3'd7;

  // event modes
  localparam logic [ModeW-1:0] ModeRelease   = 3'd0;
  localparam logic [ModeW-1:0] ModeClaimBusy = 3'd1;
  localparam logic [ModeW-1:0] ModeClaimInit = 3'd2;
  localparam logic [ModeW-1:0] ModeShutdown  = 3'd3;
  localparam logic [ModeW-1:0] ModeTick      = 3'd4;

  // target replies
  localparam logic [ReplyW-1:0] ReplyDelivered = 2'd0;
  localparam logic [ReplyW-1:0] ReplyNoTarget  = 2'd1;

  // result status
  localparam logic [StatW-1:0] StatOk      = 2'd0;
  localparam logic [StatW-1:0] StatRefused = 2'd1;
  localparam logic [StatW-1:0] StatFatal   = 2'd2;

  // signals sent
  localparam logic [SigW-1:0] SigNone  = 2'd0;
  localparam logic [SigW-1:0] SigTerm  = 2'd1;
  localparam logic [SigW-1:0] SigKill  = 2'd2;
  localparam logic [SigW-1:0] SigProbe = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [OwnerW-1:0] owner_id;
    logic [ReplyW-1:0] target_reply;
  } item_t;

  typedef struct packed {
    logic [StateW-1:0] life_state;
    logic [OwnerW-1:0] owner;
    logic [TickW-1:0]  elapsed;
  } ctx_t;

  typedef struct packed {
    logic [StateW-1:0] life_state;
    logic [StatW-1:0]  status;
    logic [SigW-1:0]   signal_sent;
    logic              link_closed;
    logic [OwnerW-1:0] current_owner;
  } result_t;

endpackage

/* rtl/core/wlsf_in_stage.sv */
// Input register stage: holds one accepted item until the step logic takes it.
// Depends on wlsf_pkg.
module wlsf_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  wlsf_pkg::item_t item_i,
  input  logic           take_i,
  output logic           vld_o,
  output wlsf_pkg::item_t item_o
);

  logic           vld_q, vld_d;
  logic           load;
  wlsf_pkg::item_t item_q;

  assign in_stall_o = vld_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign vld_d      = load || (vld_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

/* rtl/core/wlsf_step.sv */
// Combinational lifecycle step: next context and result for one item.
// Depends on wlsf_pkg.
module wlsf_step (
  input  wlsf_pkg::item_t              item_i,
  input  wlsf_pkg::ctx_t               ctx_i,
  input  logic [wlsf_pkg::TickW-1:0]   timeout_i,
  output wlsf_pkg::ctx_t               ctx_o,
  output wlsf_pkg::result_t            res_o
);

  logic                         expired;
  logic [wlsf_pkg::StateW-1:0]  st_d;
  logic [wlsf_pkg::OwnerW-1:0]  own_d;
  logic [wlsf_pkg::TickW-1:0]   elp_d;
  logic [wlsf_pkg::StatW-1:0]   stat;
  logic [wlsf_pkg::SigW-1:0]    sig;
  logic                         closed;
  logic                         sig_done;   // term or kill went out
  logic                         probe_done;

  assign expired = ctx_i.elapsed > timeout_i;

  always_comb begin
    st_d       = ctx_i.life_state;
    own_d      = ctx_i.owner;
    elp_d      = ctx_i.elapsed;
    stat       = wlsf_pkg::StatOk;
    sig        = wlsf_pkg::SigNone;
    closed     = 1'b0;
    sig_done   = 1'b0;
    probe_done = 1'b0;

    case (item_i.mode)
      wlsf_pkg::ModeRelease: begin
        if (ctx_i.life_state == wlsf_pkg::StStart || ctx_i.life_state == wlsf_pkg::StInit ||
            ctx_i.life_state == wlsf_pkg::StBusy  || ctx_i.life_state == wlsf_pkg::StIdle) begin
          st_d  = wlsf_pkg::StIdle;
          own_d = '0;
        end else begin
          stat = wlsf_pkg::StatRefused;
        end
      end
      wlsf_pkg::ModeClaimBusy: begin
        if (ctx_i.life_state == wlsf_pkg::StIdle || ctx_i.life_state == wlsf_pkg::StBusy) begin
          st_d  = wlsf_pkg::StBusy;
          own_d = item_i.owner_id;
        end else begin
          stat = wlsf_pkg::StatRefused;
        end
      end
      wlsf_pkg::ModeClaimInit: begin
        if (ctx_i.life_state == wlsf_pkg::StStart || ctx_i.life_state == wlsf_pkg::StInit) begin
          st_d  = wlsf_pkg::StInit;
          own_d = item_i.owner_id;
        end else begin
          stat = wlsf_pkg::StatRefused;
        end
      end
      wlsf_pkg::ModeShutdown: begin
        if (ctx_i.life_state <= wlsf_pkg::StBusy) begin
          st_d     = wlsf_pkg::StTerm;
          sig      = wlsf_pkg::SigTerm;
          sig_done = 1'b1;
        end else if (ctx_i.life_state == wlsf_pkg::StTerm) begin
          if (expired) begin
            st_d     = wlsf_pkg::StKill;
            sig      = wlsf_pkg::SigKill;
            sig_done = 1'b1;
          end else begin
            sig        = wlsf_pkg::SigProbe;
            probe_done = 1'b1;
          end
        end else if (ctx_i.life_state == wlsf_pkg::StKill) begin
          if (expired) begin
            st_d   = wlsf_pkg::StExit;
            closed = 1'b1;
          end else begin
            sig        = wlsf_pkg::SigProbe;
            probe_done = 1'b1;
          end
        end
      end
      wlsf_pkg::ModeTick: begin
        if (ctx_i.elapsed != wlsf_pkg::TickMax) begin
          elp_d = ctx_i.elapsed + wlsf_pkg::TickW'(1);
        end
      end
      default: begin
        stat = wlsf_pkg::StatRefused;
      end
    endcase

    // reply handling for whatever went out
    if (sig_done) begin
      if (item_i.target_reply == wlsf_pkg::ReplyDelivered) begin
        elp_d = '0;
      end else if (item_i.target_reply == wlsf_pkg::ReplyNoTarget) begin
        st_d   = wlsf_pkg::StExit;
        closed = 1'b1;
      end else begin
        stat = wlsf_pkg::StatFatal;
      end
    end
    if (probe_done && item_i.target_reply == wlsf_pkg::ReplyNoTarget) begin
      st_d   = wlsf_pkg::StExit;
      closed = 1'b1;
    end
  end

  assign ctx_o.life_state    = st_d;
  assign ctx_o.owner         = own_d;
  assign ctx_o.elapsed       = elp_d;
  assign res_o.life_state    = st_d;
  assign res_o.status        = stat;
  assign res_o.signal_sent   = sig;
  assign res_o.link_closed   = closed;
  assign res_o.current_owner = own_d;

endmodule

/* rtl/core/wlsf_out_stage.sv */
// Result register stage: holds one result until the consumer takes it.
// Depends on wlsf_pkg.
module wlsf_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  wlsf_pkg::result_t res_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wlsf_pkg::result_t res_o
);

  logic              vld_q, vld_d;
  wlsf_pkg::result_t res_q;

  assign ready_o = !vld_q || !out_stall_i;
  assign vld_d   = load_i || (vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/worker_lifecycle_shutdown_fsm.sv */
// Worker lifecycle / shutdown FSM, top level.
// Path: an accepted item waits in the input reg, and its result is loaded into the result
// reg once that reg has room (input reg, then result reg).
// Throughput: one item per cycle; a stalled full result reg stalls the input.
// Reset (rst_ni low, async): state start, no owner, elapsed 0, timeout 10, both
// stages empty. Depends on wlsf_pkg, wlsf_in_stage, wlsf_step, wlsf_out_stage.
module worker_lifecycle_shutdown_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wlsf_pkg::ModeW-1:0]    mode_i,
  input  logic [wlsf_pkg::OwnerW-1:0]   owner_id_i,
  input  logic [wlsf_pkg::ReplyW-1:0]   target_reply_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wlsf_pkg::StateW-1:0]   life_state_o,
  output logic [wlsf_pkg::StatW-1:0]    status_o,
  output logic [wlsf_pkg::SigW-1:0]     signal_sent_o,
  output logic                          link_closed_o,
  output logic [wlsf_pkg::OwnerW-1:0]   current_owner_o,
  // timeout register write
  input  logic                          cfg_we_i,
  input  logic [wlsf_pkg::TickW-1:0]    cfg_wdata_i
);

  wlsf_pkg::item_t   in_item, stg_item;
  wlsf_pkg::ctx_t    ctx_q, ctx_d;
  wlsf_pkg::result_t step_res, out_res;
  logic              stg_vld;
  logic              out_ready;
  logic              fire;        // step item retires into the result reg
  logic [wlsf_pkg::TickW-1:0] timeout_q;

  assign in_item.mode         = mode_i;
  assign in_item.owner_id     = owner_id_i;
  assign in_item.target_reply = target_reply_i;

  // The staged item retires whenever the result reg has room; the state
  // update and the result load happen on that same edge, so the next staged
  // item always sees the context left by the one before it.
  assign fire = stg_vld && out_ready;

  wlsf_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (fire),
    .vld_o      (stg_vld),
    .item_o     (stg_item)
  );

  wlsf_step u_step (
    .item_i    (stg_item),
    .ctx_i     (ctx_q),
    .timeout_i (timeout_q),
    .ctx_o     (ctx_d),
    .res_o     (step_res)
  );

  // lifecycle context and timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.life_state <= wlsf_pkg::StStart;
      ctx_q.owner      <= '0;
      ctx_q.elapsed    <= '0;
      timeout_q        <= wlsf_pkg::TimeoutReset;
    end else begin
      if (fire) begin
        ctx_q <= ctx_d;
      end
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  wlsf_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (step_res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign life_state_o    = out_res.life_state;
  assign status_o        = out_res.status;
  assign signal_sent_o   = out_res.signal_sent;
  assign link_closed_o   = out_res.link_closed;
  assign current_owner_o = out_res.current_owner;

`ifndef SYNTHESIS
  // open idle is never entered by any event
  a_no_open_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_q.life_state != wlsf_pkg::StOpenIdle)
    else $error("lifecycle entered open idle");

  // a closed link always reports the exit state
  a_closed_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && link_closed_o) |-> (life_state_o == wlsf_pkg::StExit))
    else $error("link closed outside exit");

  // fatal status only follows a terminate or kill signal
  a_fatal_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == wlsf_pkg::StatFatal) |->
    (signal_sent_o == wlsf_pkg::SigTerm || signal_sent_o == wlsf_pkg::SigKill))
    else $error("fatal status without signal");

  // context changes only when an item retires
  a_ctx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(ctx_q))
    else $error("context changed without an item");
`endif

endmodule
